/* rtl/core/dwbr_pkg.sv */
// dwbr_pkg: shared types, constants and the quadrant coefficient table for
// the disc warp resampler. No dependencies.
`default_nettype none
package dwbr_pkg;

	localparam int MAX_DIM_DEF      = 512;
	localparam int WEIGHT_FRAC_DEF  = 8;
	localparam int CHANNELS         = 3;
	localparam int CFG_W            = 10;
	localparam int ROW_W            = 9;
	localparam int PIX_W            = 24;
	localparam int COEF_W           = 24;
	localparam int CRD_W            = 12;
	localparam int SQ_W             = 24;
	localparam int PROD_W           = 48;
	localparam int POS_FRAC         = 24;
	localparam int DISC_R2          = 263169;   // 513^2, doubled radius squared
	localparam logic [CFG_W-1:0] DIM_RESET = 10'd512;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_WARP = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		QUAD_NW = 2'd0,   // X < 0, Y > 0
		QUAD_NE = 2'd1,   // X > 0, Y > 0
		QUAD_SE = 2'd2,   // X > 0, Y < 0
		QUAD_SW = 2'd3    // X < 0, Y < 0
	} quad_t;

	typedef enum logic [2:0] {
		C_AX = 3'd0,
		C_BX = 3'd1,
		C_CX = 3'd2,
		C_AY = 3'd3,
		C_BY = 3'd4,
		C_CY = 3'd5
	} coef_sel_t;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic valid;
		logic in_disc;
	} ctl_t;

	// Q2.22 polynomial coefficients per quadrant
	function automatic coef_t coef_lookup(input quad_t q, input coef_sel_t s);
		coef_t r;
		r = '0;
		case (q)
			QUAD_NW: begin
				case (s)
					C_AX: r = coef_t'(4189569);
					C_BX: r = coef_t'(4740);
					C_CX: r = coef_t'(9500);
					C_AY: r = coef_t'(4731);
					C_BY: r = coef_t'(4189560);
					C_CY: r = coef_t'(-9500);
					default: r = '0;
				endcase
			end
			QUAD_NE: begin
				case (s)
					C_AX: r = coef_t'(4189569);
					C_BX: r = coef_t'(4706);
					C_CX: r = coef_t'(9450);
					C_AY: r = coef_t'(-4735);
					C_BY: r = coef_t'(4199010);
					C_CY: r = coef_t'(9399);
					default: r = '0;
				endcase
			end
			QUAD_SE: begin
				case (s)
					C_AX: r = coef_t'(4199004);
					C_BX: r = coef_t'(-4706);
					C_CX: r = coef_t'(-9399);
					C_AY: r = coef_t'(-4700);
					C_BY: r = coef_t'(4199010);
					C_CY: r = coef_t'(9399);
					default: r = '0;
				endcase
			end
			default: begin
				case (s)
					C_AX: r = coef_t'(4199010);
					C_BX: r = coef_t'(-4723);
					C_CX: r = coef_t'(-9450);
					C_AY: r = coef_t'(4708);
					C_BY: r = coef_t'(4189577);
					C_CY: r = coef_t'(-9450);
					default: r = '0;
				endcase
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/dwbr_map.sv */
// dwbr_map: coordinate pipeline, stages 2 to 6: centring, disc test,
// polynomial mapping and split into pixel index and weight. Uses dwbr_pkg.
`default_nettype none
module dwbr_map import dwbr_pkg::*; #(
	parameter int MAX_DIM          = MAX_DIM_DEF,
	parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEF,
	localparam int DIM_W           = $clog2(MAX_DIM)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        warp_s1,
	input  logic [ROW_W-1:0]            row_s1,
	input  logic [ROW_W-1:0]            col_s1,
	input  logic [DIM_W:0]              w_eff,
	input  logic [DIM_W:0]              h_eff,
	output ctl_t                        ctl_s6,
	output logic [DIM_W-1:0]            ir_s6,
	output logic [DIM_W-1:0]            ic_s6,
	output logic [WEIGHT_FRAC_BITS-1:0] fr_s6,
	output logic [WEIGHT_FRAC_BITS-1:0] fc_s6
);

	localparam int IP_W = PROD_W - POS_FRAC;
	localparam logic signed [PROD_W-1:0] OFF_COL = PROD_W'(511) <<< (POS_FRAC - 1);

	logic v_s2, v_s3, v_s4, v_s5;

	logic signed [CRD_W-1:0] x2_c, y2_c;
	quad_t                   quad_c;
	logic signed [CRD_W-1:0] x2_s2, y2_s2, x2_s3, y2_s3;
	quad_t                   quad_s2;

	logic signed [SQ_W-1:0]  sqx_s3, sqy_s3, xy_s3;
	coef_t                   ax_s3, bx_s3, cx_s3, ay_s3, by_s3, cy_s3;

	logic [SQ_W:0]           r2_c;
	logic                    inside_s4, inside_s5;
	logic signed [PROD_W-1:0] pax_s4, pbx_s4, pcx_s4, pay_s4, pby_s4, pcy_s4;

	logic signed [PROD_W-1:0] row_base_c;
	logic signed [PROD_W-1:0] pos_c_s5, pos_r_s5;

	logic [PROD_W-1:0]           pc_nn, pr_nn;
	logic [IP_W-1:0]             ipc, ipr;
	logic [DIM_W:0]              w_m1, h_m1;
	logic [DIM_W-1:0]            ic_c, ir_c;
	logic [WEIGHT_FRAC_BITS-1:0] fc_c, fr_c;

	// stage 2: doubled centred coordinates, quadrant
	assign x2_c = CRD_W'({2'b00, col_s1, 1'b1}) - CRD_W'(512);
	assign y2_c = CRD_W'({h_eff, 1'b0}) - CRD_W'({row_s1, 1'b1}) - CRD_W'(512);

	always_comb begin
		if (x2_c[CRD_W-1]) begin
			quad_c = (!y2_c[CRD_W-1] && y2_c != '0) ? QUAD_NW : QUAD_SW;
		end else begin
			quad_c = (!y2_c[CRD_W-1] && y2_c != '0) ? QUAD_NE : QUAD_SE;
		end
	end

	// stage 4 radius test on squares
	assign r2_c = (SQ_W+1)'($unsigned(sqx_s3)) + (SQ_W+1)'($unsigned(sqy_s3));

	// stage 5 row origin: (2H - 513) in units of 2^-1, i.e. half pixels
	assign row_base_c = PROD_W'({h_eff, 1'b0}) - PROD_W'(513);

	// stage 6: floor, split, clamp
	assign pc_nn = pos_c_s5[PROD_W-1] ? '0 : pos_c_s5;
	assign pr_nn = pos_r_s5[PROD_W-1] ? '0 : pos_r_s5;
	assign ipc   = pc_nn[PROD_W-1:POS_FRAC];
	assign ipr   = pr_nn[PROD_W-1:POS_FRAC];
	assign w_m1  = w_eff - 1'b1;
	assign h_m1  = h_eff - 1'b1;

	always_comb begin
		if (ipc >= IP_W'(w_m1)) begin
			ic_c = w_m1[DIM_W-1:0];
			fc_c = '0;
		end else begin
			ic_c = ipc[DIM_W-1:0];
			fc_c = pc_nn[POS_FRAC-1 -: WEIGHT_FRAC_BITS];
		end
		if (ipr >= IP_W'(h_eff)) begin
			ir_c = h_m1[DIM_W-1:0];
			fr_c = '0;
		end else begin
			ir_c = ipr[DIM_W-1:0];
			fr_c = pr_nn[POS_FRAC-1 -: WEIGHT_FRAC_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			ctl_s6 <= '0;
		end else if (en) begin
			v_s2   <= warp_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			ctl_s6 <= '{valid: v_s5, in_disc: inside_s5};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s2     <= x2_c;
			y2_s2     <= y2_c;
			quad_s2   <= quad_c;

			x2_s3     <= x2_s2;
			y2_s3     <= y2_s2;
			sqx_s3    <= SQ_W'(x2_s2) * SQ_W'(x2_s2);
			sqy_s3    <= SQ_W'(y2_s2) * SQ_W'(y2_s2);
			xy_s3     <= SQ_W'(x2_s2) * SQ_W'(y2_s2);
			ax_s3     <= coef_lookup(quad_s2, C_AX);
			bx_s3     <= coef_lookup(quad_s2, C_BX);
			cx_s3     <= coef_lookup(quad_s2, C_CX);
			ay_s3     <= coef_lookup(quad_s2, C_AY);
			by_s3     <= coef_lookup(quad_s2, C_BY);
			cy_s3     <= coef_lookup(quad_s2, C_CY);

			inside_s4 <= (r2_c <= (SQ_W+1)'(DISC_R2));
			pax_s4    <= PROD_W'(ax_s3) * PROD_W'(x2_s3);
			pbx_s4    <= PROD_W'(bx_s3) * PROD_W'(y2_s3);
			pcx_s4    <= PROD_W'(cx_s3) * PROD_W'(xy_s3);
			pay_s4    <= PROD_W'(ay_s3) * PROD_W'(x2_s3);
			pby_s4    <= PROD_W'(by_s3) * PROD_W'(y2_s3);
			pcy_s4    <= PROD_W'(cy_s3) * PROD_W'(xy_s3);

			inside_s5 <= inside_s4;
			pos_c_s5  <= ((pax_s4 + pbx_s4) <<< 1) + pcx_s4 + OFF_COL;
			pos_r_s5  <= (row_base_c <<< (POS_FRAC - 1)) - ((pay_s4 + pby_s4) <<< 1) - pcy_s4;

			ir_s6     <= ir_c;
			ic_s6     <= ic_c;
			fr_s6     <= fr_c;
			fc_s6     <= fc_c;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/dwbr_store.sv */
// dwbr_store: frame store as four banks split by row and column parity, so
// all four neighbours are read in the same cycle. Uses dwbr_pkg.
`default_nettype none
module dwbr_store import dwbr_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	localparam int DIM_W  = $clog2(MAX_DIM)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [ROW_W-1:0] wr_row,
	input  logic [ROW_W-1:0] wr_col,
	input  logic [PIX_W-1:0] wr_data,
	input  logic [DIM_W-1:0] rd_row,
	input  logic [DIM_W-1:0] rd_col,
	input  logic [DIM_W:0]   w_eff,
	input  logic [DIM_W:0]   h_eff,
	output logic [PIX_W-1:0] q00,
	output logic [PIX_W-1:0] q01,
	output logic [PIX_W-1:0] q10,
	output logic [PIX_W-1:0] q11
);

	localparam int HALF_W     = (DIM_W > 1) ? DIM_W - 1 : 1;
	localparam int ADDR_W     = 2 * HALF_W;
	localparam int BANK_DEPTH = 1 << ADDR_W;

	logic [DIM_W:0]   col_inc, row_inc;
	logic [DIM_W-1:0] col1, row1;
	logic [1:0]       wr_bank;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr [4];
	logic [PIX_W-1:0]  bank_rd [4];
	logic pr0_s7, pr1_s7, pc0_s7, pc1_s7;

	// right and lower neighbours, replicated at the edge
	assign col_inc = {1'b0, rd_col} + 1'b1;
	assign row_inc = {1'b0, rd_row} + 1'b1;
	assign col1    = (col_inc < w_eff) ? col_inc[DIM_W-1:0] : rd_col;
	assign row1    = (row_inc < h_eff) ? row_inc[DIM_W-1:0] : rd_row;

	assign wr_bank = {wr_row[0], wr_col[0]};
	assign wr_addr = {HALF_W'(wr_row >> 1), HALF_W'(wr_col >> 1)};

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			rd_addr[b] = {HALF_W'(((rd_row[0] == b[1]) ? rd_row : row1) >> 1),
				HALF_W'(((rd_col[0] == b[0]) ? rd_col : col1) >> 1)};
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_bank
		logic [PIX_W-1:0] mem [BANK_DEPTH];
		logic [PIX_W-1:0] rd_s7;

		always_ff @(posedge clk) begin
			if (we && wr_bank == 2'(g)) begin
				mem[wr_addr] <= wr_data;
			end
			if (en) begin
				rd_s7 <= mem[rd_addr[g]];
			end
		end

		assign bank_rd[g] = rd_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr0_s7 <= rd_row[0];
			pr1_s7 <= row1[0];
			pc0_s7 <= rd_col[0];
			pc1_s7 <= col1[0];
		end
	end

	assign q00 = bank_rd[{pr0_s7, pc0_s7}];
	assign q01 = bank_rd[{pr0_s7, pc1_s7}];
	assign q10 = bank_rd[{pr1_s7, pc0_s7}];
	assign q11 = bank_rd[{pr1_s7, pc1_s7}];

endmodule
`default_nettype wire

/* rtl/core/disc_warp_bilinear_resampler_unit.sv */
// disc_warp_bilinear_resampler_unit: top level of the disc warp resampler.
// Uses dwbr_pkg, dwbr_map and dwbr_store.
//
// Usage
//  - Input channel (item_valid / item_stall): one word per pixel. action =
//    load writes red_in/green_in/blue_in at (row, col) of the frame store;
//    action = warp asks for the output pixel at (row, col).
//  - Result channel (result_valid / result_stall): one word per warp word,
//    none per load word, in order. Outside the radius-256.5 disc the colour
//    is black and inside_disc is low.
//  - cfg_we / cfg_index / cfg_data set image_width and image_height; write
//    them only while nothing is in flight.
//  - Throughput: one word per cycle, loads and warps freely mixed. A load
//    travels with the coordinate pipe and writes the store at stage 6, the
//    stage where warps read it, so a warp sees exactly the loads taken
//    before it and none taken after it.
//  - Pipeline: a warp result passes nine stages (input register, centring,
//    squares, products, sums, split, store read, horizontal blend, vertical
//    blend into the output register).
//  - Stall: result_stall with a word waiting freezes the whole pipeline;
//    item_stall follows it in the same cycle. Nothing is lost or repeated.
//  - Reset clears the valid bits and sets both sizes to 512. The store is
//    not cleared; reading a pixel never loaded gives junk.
`default_nettype none
module disc_warp_bilinear_resampler_unit import dwbr_pkg::*; #(
	parameter int MAX_DIM          = MAX_DIM_DEF,
	parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic             action,
	input  logic [ROW_W-1:0] row,
	input  logic [ROW_W-1:0] col,
	input  logic [7:0]       red_in,
	input  logic [7:0]       green_in,
	input  logic [7:0]       blue_in,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [7:0]       red_out,
	output logic [7:0]       green_out,
	output logic [7:0]       blue_out,
	output logic             inside_disc,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int DIM_W = $clog2(MAX_DIM);
	localparam int WF    = WEIGHT_FRAC_BITS;
	localparam int HW    = 8 + WF + 1;       // one-axis blend
	localparam int VW    = 8 + 2 * WF + 1;   // two-axis blend
	localparam logic [WF:0] W_ONE = (WF+1)'(1) << WF;
	localparam int LD_W  = 1 + 2 * ROW_W + PIX_W;   // write enable, row, col, pixel

	logic             en;
	logic [CFG_W-1:0] image_width_q, image_height_q;
	logic [DIM_W:0]   w_eff, h_eff;

	logic             v_s1;
	action_t          action_s1;
	logic [ROW_W-1:0] row_s1, col_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             store_we;
	logic [LD_W-1:0]  ld_s2, ld_s3, ld_s4, ld_s5, ld_s6;

	ctl_t             ctl_s6, ctl_s7, ctl_s8;
	logic [DIM_W-1:0] ir_s6, ic_s6;
	logic [WF-1:0]    fr_s6, fc_s6, fr_s7, fc_s7, fr_s8;
	logic [PIX_W-1:0] q00, q01, q10, q11;

	logic [WF:0]      inv_fc, inv_fr;
	logic [HW-1:0]    top_s8 [CHANNELS];
	logic [HW-1:0]    bot_s8 [CHANNELS];
	logic [VW-1:0]    blend_c [CHANNELS];

	logic             v_s9;
	logic             inside_s9;
	logic [7:0]       chan_s9 [CHANNELS];

	// whole pipeline moves unless a finished word is held at the output
	assign en         = !(v_s9 && result_stall);
	assign item_stall = !en;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_RESET;
			image_height_q <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize as MAX_DIM
	always_comb begin
		if (image_width_q == '0) begin
			w_eff = (DIM_W+1)'(1);
		end else if (32'(image_width_q) > MAX_DIM) begin
			w_eff = (DIM_W+1)'(MAX_DIM);
		end else begin
			w_eff = (DIM_W+1)'(image_width_q);
		end
		if (image_height_q == '0) begin
			h_eff = (DIM_W+1)'(1);
		end else if (32'(image_height_q) > MAX_DIM) begin
			h_eff = (DIM_W+1)'(MAX_DIM);
		end else begin
			h_eff = (DIM_W+1)'(image_height_q);
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			action_s1 <= action_t'(action);
			row_s1    <= row;
			col_s1    <= col;
			pix_s1    <= {blue_in, green_in, red_in};
		end
	end

	// loads beyond the store are dropped
	assign store_we = v_s1 && action_s1 == ACT_LOAD
		&& 32'(row_s1) < MAX_DIM && 32'(col_s1) < MAX_DIM;

	// load path kept in step with the map, so it writes at the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_s2 <= '0;
			ld_s3 <= '0;
			ld_s4 <= '0;
			ld_s5 <= '0;
			ld_s6 <= '0;
		end else if (en) begin
			ld_s2 <= {store_we, row_s1, col_s1, pix_s1};
			ld_s3 <= ld_s2;
			ld_s4 <= ld_s3;
			ld_s5 <= ld_s4;
			ld_s6 <= ld_s5;
		end
	end

	dwbr_map #(
		.MAX_DIM          (MAX_DIM),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.warp_s1 (v_s1 && action_s1 == ACT_WARP),
		.row_s1  (row_s1),
		.col_s1  (col_s1),
		.w_eff   (w_eff),
		.h_eff   (h_eff),
		.ctl_s6  (ctl_s6),
		.ir_s6   (ir_s6),
		.ic_s6   (ic_s6),
		.fr_s6   (fr_s6),
		.fc_s6   (fc_s6)
	);

	dwbr_store #(
		.MAX_DIM (MAX_DIM)
	) u_store (
		.clk     (clk),
		.en      (en),
		.we      (ld_s6[LD_W-1] && en),
		.wr_row  (ld_s6[LD_W-2 -: ROW_W]),
		.wr_col  (ld_s6[PIX_W +: ROW_W]),
		.wr_data (ld_s6[PIX_W-1:0]),
		.rd_row  (ir_s6),
		.rd_col  (ic_s6),
		.w_eff   (w_eff),
		.h_eff   (h_eff),
		.q00     (q00),
		.q01     (q01),
		.q10     (q10),
		.q11     (q11)
	);

	assign inv_fc = W_ONE - (WF+1)'(fc_s7);
	assign inv_fr = W_ONE - (WF+1)'(fr_s8);

	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			blend_c[ch] = VW'(top_s8[ch]) * VW'(inv_fr) + VW'(bot_s8[ch]) * VW'(fr_s8);
		end
	end

	// stages 7 to 9: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			v_s9   <= 1'b0;
		end else if (en) begin
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
			v_s9   <= ctl_s8.valid;
		end
	end

	// stages 7 to 9: weights, blends, output word
	always_ff @(posedge clk) begin
		if (en) begin
			fr_s7 <= fr_s6;
			fc_s7 <= fc_s6;
			fr_s8 <= fr_s7;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				top_s8[ch] <= HW'(q00[8*ch +: 8]) * HW'(inv_fc) + HW'(q01[8*ch +: 8]) * HW'(fc_s7);
				bot_s8[ch] <= HW'(q10[8*ch +: 8]) * HW'(inv_fc) + HW'(q11[8*ch +: 8]) * HW'(fc_s7);
				chan_s9[ch] <= ctl_s8.in_disc ? blend_c[ch][2*WF +: 8] : 8'd0;
			end
			inside_s9 <= ctl_s8.in_disc;
		end
	end

	assign result_valid = v_s9;
	assign red_out      = chan_s9[0];
	assign green_out    = chan_s9[1];
	assign blue_out     = chan_s9[2];
	assign inside_disc  = inside_s9;

endmodule
`default_nettype wire

/* rtl/core/dwbr_checker.sv */
// dwbr_assertions: port-level assertions for the disc warp resampler, bound
// to the top level below. Depends on the top level's ports only.
`default_nettype none
module dwbr_assertions (
	input logic             clk,
	input logic             arst_n,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input logic [7:0]       red_out,
	input logic [7:0]       green_out,
	input logic [7:0]       blue_out,
	input logic             inside_disc
);

	// input back-pressure only comes from a held result word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("item_stall without a held result");

	// outside the disc the word is black
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !inside_disc) |->
			(red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0))
		else $error("non-black word outside disc");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid)
		else $error("result word dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
			$stable({red_out, green_out, blue_out, inside_disc}))
		else $error("result word changed under stall");

endmodule

bind disc_warp_bilinear_resampler_unit dwbr_assertions u_dwbr_assertions (.*);
`default_nettype wire

/* tb/dwbr_checker.sv */
// dwbr_checker: watches the word and result channels of the disc warp resampler,
// keeps its own frame store and size registers, predicts each warp result, compares.
// Depends on dwbr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dwbr_checker import dwbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_stall,
	input  logic       action,
	input  logic [8:0] row,
	input  logic [8:0] col,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic       result_valid,
	input  logic       result_stall,
	input  logic [7:0] red_out,
	input  logic [7:0] green_out,
	input  logic [7:0] blue_out,
	input  logic       inside_disc,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [9:0] cfg_data,
	output int         fail_count,
	output int         pending
);

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       ins;
	} pixel_res_t;

	// ax bx cx ay by cy, Q2.22, per quadrant
	localparam longint KTAB [4][6] = '{
		'{4189569, 4740, 9500, 4731, 4189560, -9500},
		'{4189569, 4706, 9450, -4735, 4199010, 9399},
		'{4199004, -4706, -9399, -4700, 4199010, 9399},
		'{4199010, -4723, -9450, 4708, 4189577, -9450}
	};

	logic [23:0]   shadow_mem [262144];
	logic [9:0]    width_reg, height_reg;
	pixel_res_t    due_q [$];
	int            mism;

	function automatic longint eff_dim(input logic [9:0] v);
		if (v == 0) return 1;
		if (v > 512) return 512;
		return longint'(v);
	endfunction

	function automatic void split_pos(input longint p, input longint lim,
			output longint ip, output longint fp);
		longint q;
		if (p < 0) p = 0;
		q = p >>> 16;
		ip = q >>> 8;
		fp = q & 255;
		if (ip >= lim) begin
			ip = lim - 1;
			fp = 0;
		end
	endfunction

	// source taps of a warp pixel; returns 0 when outside the disc
	function automatic bit warp_taps(input logic [8:0] r, input logic [8:0] c,
			input logic [9:0] wr, input logic [9:0] hr,
			output longint ir, output longint ic, output longint ir1,
			output longint ic1, output longint fr, output longint fc);
		longint w, h, x2, y2, sx, sy;
		quad_t  qd;
		w = eff_dim(wr);
		h = eff_dim(hr);
		x2 = 2 * longint'(c) + 1 - 512;
		y2 = 2 * h - 1 - 2 * longint'(r) - 512;
		ir = 0; ic = 0; ir1 = 0; ic1 = 0; fr = 0; fc = 0;
		if (x2 * x2 + y2 * y2 > 513 * 513) return 0;
		if (x2 < 0) qd = (y2 > 0) ? QUAD_NW : QUAD_SW;
		else        qd = (y2 > 0) ? QUAD_NE : QUAD_SE;
		sx = 2 * KTAB[qd][0] * x2 + 2 * KTAB[qd][1] * y2 + KTAB[qd][2] * x2 * y2;
		sy = 2 * KTAB[qd][3] * x2 + 2 * KTAB[qd][4] * y2 + KTAB[qd][5] * x2 * y2;
		split_pos(sx + 511 * (longint'(1) << 23), w, ic, fc);
		if (ic >= w - 1) begin
			ic = w - 1;
			fc = 0;
		end
		split_pos((2 * h - 513) * (longint'(1) << 23) - sy, h, ir, fr);
		ic1 = (ic + 1 < w) ? ic + 1 : ic;
		ir1 = (ir + 1 < h) ? ir + 1 : ir;
		return 1;
	endfunction

	function automatic pixel_res_t predict_pixel(input logic [8:0] r, input logic [8:0] c);
		longint     ir, ic, ir1, ic1, fr, fc, top, bot, v;
		logic [23:0] p00, p01, p10, p11;
		pixel_res_t res;
		logic [7:0] ch [3];
		res = '0;
		if (!warp_taps(r, c, width_reg, height_reg, ir, ic, ir1, ic1, fr, fc)) return res;
		p00 = shadow_mem[ir * 512 + ic];
		p01 = shadow_mem[ir * 512 + ic1];
		p10 = shadow_mem[ir1 * 512 + ic];
		p11 = shadow_mem[ir1 * 512 + ic1];
		for (int k = 0; k < 3; k++) begin
			top = longint'(p00[8*k +: 8]) * (256 - fc) + longint'(p01[8*k +: 8]) * fc;
			bot = longint'(p10[8*k +: 8]) * (256 - fc) + longint'(p11[8*k +: 8]) * fc;
			v = top * (256 - fr) + bot * fr;
			ch[k] = 8'(v >>> 16);
		end
		res.r = ch[0];
		res.g = ch[1];
		res.b = ch[2];
		res.ins = 1'b1;
		return res;
	endfunction

	assign fail_count = mism;
	assign pending = due_q.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_res_t got, want;
		if (!arst_n) begin
			width_reg <= 10'd512;
			height_reg <= 10'd512;
			mism = 0;
			due_q.delete();
		end else begin
			if (item_valid && !item_stall) begin
				if (action == ACT_LOAD)
					shadow_mem[{row, col}] = {blue_in, green_in, red_in};
				else
					due_q.push_back(predict_pixel(row, col));
			end
			if (result_valid && !result_stall) begin
				got = '{red_out, green_out, blue_out, inside_disc};
				if (due_q.size() == 0) begin
					mism++;
					if (mism <= 10) $display("unexpected result word %h", got);
				end else begin
					want = due_q.pop_front();
					if (got !== want) begin
						mism++;
						if (mism <= 10)
							$display("mismatch: want r%h g%h b%h in%b got r%h g%h b%h in%b",
								want.r, want.g, want.b, want.ins,
								got.r, got.g, got.b, got.ins);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_IMAGE_WIDTH) width_reg <= cfg_data;
				else height_reg <= cfg_data;
			end
		end
	end

endmodule
`default_nettype wire

/* tb/disc_warp_bilinear_resampler_unit_tb.sv */
// disc_warp_bilinear_resampler_unit_tb: stimulus and verdict for the disc warp resampler.
// Depends on dwbr_pkg, the block and dwbr_checker.
`timescale 1ns / 1ps
`default_nettype none
module disc_warp_bilinear_resampler_unit_tb;
	import dwbr_pkg::*;

	logic       clk, arst_n;
	logic       item_valid, item_stall, action;
	logic [8:0] row, col;
	logic [7:0] red_in, green_in, blue_in;
	logic       result_valid, result_stall;
	logic [7:0] red_out, green_out, blue_out;
	logic       inside_disc;
	logic       cfg_we, cfg_index;
	logic [9:0] cfg_data;
	int         fail_count, pending;

	logic       word_taken;        // previous offer accepted at the last edge
	bit         loaded [262144];  // store entries the stimulus has written
	logic [9:0] cur_w, cur_h;
	int         send_idle_pct, recv_stall_pct;
	int         hold_len;          // receiver hold-off request, in cycles
	int         cycles, warps_sent;

	disc_warp_bilinear_resampler_unit u_top (.*);

	dwbr_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// acceptance seen at the edge, consumed by the sender at the next falling edge
	always @(posedge clk) word_taken <= item_valid && !item_stall;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off when asked
	initial begin
		int held;
		result_stall = 0;
		held = 0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				result_stall = 1;
				held++;
				if (held >= hold_len) begin
					hold_len = 0;
					held = 0;
				end
			end else
				result_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic send_word(input logic act, input logic [8:0] r, input logic [8:0] c,
			input logic [23:0] rgb);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid = 0;
			@(negedge clk);
		end
		action = act;
		row = r;
		col = c;
		{blue_in, green_in, red_in} = rgb;
		item_valid = 1;
		do @(negedge clk); while (!word_taken);
		if (act == ACT_LOAD) loaded[{r, c}] = 1;
	endtask

	// warp word, preceded by loads of any source tap not yet written
	task automatic warp_pixel(input logic [8:0] r, input logic [8:0] c);
		longint ir, ic, ir1, ic1, fr, fc;
		longint tr [4];
		longint tc [4];
		if (u_chk.warp_taps(r, c, cur_w, cur_h, ir, ic, ir1, ic1, fr, fc)) begin
			tr = '{ir, ir, ir1, ir1};
			tc = '{ic, ic1, ic, ic1};
			for (int k = 0; k < 4; k++)
				if (!loaded[tr[k] * 512 + tc[k]])
					send_word(ACT_LOAD, 9'(tr[k]), 9'(tc[k]), 24'($urandom));
		end
		send_word(ACT_WARP, r, c, 24'($urandom));
		warps_sent++;
	endtask

	task automatic drain;
		item_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [9:0] v);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 0;
		if (idx == REG_IMAGE_WIDTH) cur_w = v;
		else cur_h = v;
	endtask

	initial begin
		logic [9:0] wtab [7];
		logic [9:0] htab [7];
		int pct_tab [4][2];
		arst_n = 0;
		item_valid = 0; action = 0; row = 0; col = 0;
		red_in = 0; green_in = 0; blue_in = 0;
		cfg_we = 0; cfg_index = 0; cfg_data = 0;
		send_idle_pct = 0; recv_stall_pct = 0; hold_len = 0;
		cycles = 0; warps_sent = 0;
		cur_w = 10'd512; cur_h = 10'd512;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: full size, corners, centre, disc rim, sample extremes
		write_reg(REG_IMAGE_WIDTH, 10'd512);
		write_reg(REG_IMAGE_HEIGHT, 10'd512);
		send_word(ACT_LOAD, 9'd255, 9'd255, 24'hffffff);
		send_word(ACT_LOAD, 9'd256, 9'd256, 24'h000000);
		send_word(ACT_LOAD, 9'd511, 9'd511, 24'hff00ff);
		warp_pixel(9'd0, 9'd0);
		warp_pixel(9'd0, 9'd511);
		warp_pixel(9'd511, 9'd0);
		warp_pixel(9'd511, 9'd511);
		warp_pixel(9'd255, 9'd255);
		warp_pixel(9'd256, 9'd256);
		warp_pixel(9'd255, 9'd256);
		warp_pixel(9'd256, 9'd255);
		warp_pixel(9'd0, 9'd255);      // top of the rim
		warp_pixel(9'd255, 9'd0);      // left of the rim
		warp_pixel(9'd511, 9'd256);    // bottom of the rim, clamped rows
		warp_pixel(9'd256, 9'd511);    // right of the rim, last column
		warp_pixel(9'd75, 9'd75);      // just inside on the diagonal
		drain();

		// sizes: zero acts as one, above range clamps, one, full, random
		wtab = '{10'd0, 10'd1023, 10'd1, 10'd512, 10'(1 + $urandom_range(30)),
			10'(2 + $urandom_range(510)), 10'd17};
		htab = '{10'd0, 10'd1023, 10'd512, 10'd1, 10'(1 + $urandom_range(30)),
			10'(2 + $urandom_range(510)), 10'd9};
		pct_tab = '{'{0, 0}, '{68, 0}, '{0, 68}, '{9, 9}};
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(REG_IMAGE_WIDTH, wtab[ph]);
			write_reg(REG_IMAGE_HEIGHT, htab[ph]);
			send_idle_pct = pct_tab[ph % 4][0];
			recv_stall_pct = pct_tab[ph % 4][1];
			for (int n = 0; n < 170; n++) begin
				if (ph == 0 && n == 20) hold_len = 300;   // fill the pipe, back up input
				if (ph == 2 && n == 80) begin
					// pause until all results are home
					item_valid = 0;
					while (pending != 0) @(negedge clk);
				end
				if ($urandom_range(99) < 20)
					send_word(ACT_LOAD, 9'($urandom), 9'($urandom), 24'($urandom));
				else
					warp_pixel(9'($urandom), 9'($urandom));
			end
			drain();
		end

		$display("run covered %0d warp words over 8 size settings, loads mixed in,", warps_sent);
		$display("with sender gaps, receiver stalls and a long receiver hold-off");
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
rtl/core/dwbr_pkg.sv
rtl/core/dwbr_map.sv
rtl/core/dwbr_store.sv
rtl/core/disc_warp_bilinear_resampler_unit.sv
rtl/core/dwbr_checker.sv
tb/dwbr_checker.sv
tb/disc_warp_bilinear_resampler_unit_tb.sv
